// ===== hw/rtl/slce_pkg.sv =====
package slce_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LEDS_DEF    = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths
    localparam int SLOT_BITS  = 24;
    localparam int COLOR_W    = 24;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int RSLOT_W    = 10;
    localparam int CMP_W      = 8;
    localparam int BIT_CNT_W  = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(SLOT_BITS - 1);

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RESET_SLOTS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_COUNT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_COUNT   = 2'd3;

    // Register reset values
    localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 11'd0;
    localparam logic [RSLOT_W-1:0] RESET_SLOTS_RST = 10'd240;
    localparam logic [CMP_W-1:0]   ZERO_COUNT_RST  = 8'd7;
    localparam logic [CMP_W-1:0]   ONE_COUNT_RST   = 8'd14;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SLOT  = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] led_count;
        logic [RSLOT_W-1:0] reset_slots;
        logic [CMP_W-1:0]   zero_count;
        logic [CMP_W-1:0]   one_count;
    } cfg_t;

    // One slot as handed from the front end to the bit serialiser
    typedef struct packed {
        logic [COLOR_W-1:0] word;
        logic               idle;
    } slot_t;

endpackage

// ===== hw/rtl/smart_led_chain_bit_encoder.sv =====
// Smart LED chain bit encoder.
// The input stream carries two kinds of transaction, selected by s_tuser: a colour write,
// which stores a 24-bit colour for one LED and produces nothing, and a slot request, which
// produces 24 output transactions of timer compare values for one LED slot, most
// significant colour bit first. After the last LED of a frame, slots are idle: the
// compare value is zero, m_tuser is high, and the inter-frame countdown runs down. A new
// frame starts on a slot request once a colour has changed (or after reset) and the countdown is zero.
// m_tlast marks the 24th value of each slot.
// Throughput: one colour write per cycle while s_tready is high; the bit serialiser emits
// one compare value per cycle while the output is not stalled, and slots stream back to back.
// A slot request passes both front-end stages, the queue and the serialiser before the output.
// The front end (store and frame state) and the serialiser are decoupled by a short
// queue, so writes keep being accepted while the output is stalled until the queue is full
// and a slot request waits in front of it. A stall on m_tready holds the output register
// and then the serialiser. After reset the colour store is swept to zero, one entry per
// cycle; s_tready stays low during that sweep. Configuration writes are taken at any time.
module smart_led_chain_bit_encoder #(
    parameter int MAX_LEDS    = slce_pkg::MAX_LEDS_DEF,
    parameter int QUEUE_DEPTH = slce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [slce_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [slce_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,   // led_index[9:0], color[33:10], zero pad
    input  logic                            s_tuser,   // req_type
    // Compare value stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // compare_value[7:0]
    output logic                            m_tuser,   // is_reset
    output logic                            m_tlast    // last_of_slot
);

    slce_pkg::cfg_t  cfg_reg;
    slce_pkg::slot_t push_data;
    slce_pkg::slot_t pop_data;
    logic            push;
    logic            q_full;
    logic            pop;
    logic            pop_valid;

    // Register file; the four indexes cover the whole address space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count   <= slce_pkg::LED_COUNT_RST;
            cfg_reg.reset_slots <= slce_pkg::RESET_SLOTS_RST;
            cfg_reg.zero_count  <= slce_pkg::ZERO_COUNT_RST;
            cfg_reg.one_count   <= slce_pkg::ONE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                slce_pkg::REG_LED_COUNT:   cfg_reg.led_count   <= cfg_wdata;
                slce_pkg::REG_RESET_SLOTS: cfg_reg.reset_slots <= cfg_wdata[9:0];
                slce_pkg::REG_ZERO_COUNT:  cfg_reg.zero_count  <= cfg_wdata[7:0];
                slce_pkg::REG_ONE_COUNT:   cfg_reg.one_count   <= cfg_wdata[7:0];
            endcase
        end
    end

    // Front end: colour store, change detection and frame sequencing
    slce_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_index  (s_tdata[9:0]),
        .in_color  (s_tdata[33:10]),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    slce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    // Back end: turns each slot into 24 compare values
    slce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_idle  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ===== hw/rtl/slce_front.sv =====
module slce_front #(
    parameter int MAX_LEDS = slce_pkg::MAX_LEDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slce_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_req,
    input  logic [slce_pkg::INDEX_W-1:0] in_index,
    input  logic [slce_pkg::COLOR_W-1:0] in_color,
    output logic                         push,
    output slce_pkg::slot_t              push_data,
    input  logic                         q_full
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);
    localparam logic [16:0]   MAX_W     = 17'(MAX_LEDS);

    // Colour store, cleared by a sweep after reset
    logic [slce_pkg::COLOR_W-1:0] mem [MAX_LEDS];
    logic [slce_pkg::COLOR_W-1:0] rd_data_reg;

    logic              clearing_reg;
    logic [AW-1:0]     clr_cnt_reg;

    // First stage: the accepted request
    logic                         f_valid_reg;
    logic                         f_slot_reg;
    logic [slce_pkg::INDEX_W-1:0] f_index_reg;
    logic [slce_pkg::COLOR_W-1:0] f_color_reg;

    // Second stage: store data is available here
    logic                         g_valid_reg;
    logic                         g_slot_reg;
    logic                         g_hit_reg;
    logic [AW-1:0]                g_addr_reg;
    logic [slce_pkg::COLOR_W-1:0] g_color_reg;

    logic                         byp_valid_reg;
    logic [slce_pkg::COLOR_W-1:0] byp_data_reg;

    // Frame state
    logic [slce_pkg::COUNT_W-1:0] pos_reg;
    logic [slce_pkg::COUNT_W-1:0] pos_next;
    logic                         pending_reg;
    logic                         pending_next;
    logic [slce_pkg::RSLOT_W-1:0] remain_reg;
    logic [slce_pkg::RSLOT_W-1:0] remain_next;

    logic [slce_pkg::COUNT_W-1:0] count_eff;
    logic [slce_pkg::COLOR_W-1:0] cur_data;
    logic                         g_ready;
    logic                         g_set;
    logic                         restart;
    logic [slce_pkg::COUNT_W-1:0] slot_pos;
    logic                         slot_hit;
    logic                         write_hit;
    logic [15:0]                  rd_addr_w;
    logic [AW-1:0]                rd_addr;
    logic [slce_pkg::RSLOT_W-1:0] remain_base;
    logic                         slot_fire;
    logic                         mem_we;
    logic [AW-1:0]                wr_addr;
    logic [slce_pkg::COLOR_W-1:0] wr_data;

    assign count_eff = ({6'd0, cfg.led_count} > MAX_W) ? slce_pkg::COUNT_W'(MAX_LEDS)
                                                        : cfg.led_count;

    assign cur_data = byp_valid_reg ? byp_data_reg : rd_data_reg;
    assign g_set    = g_valid_reg && !g_slot_reg && g_hit_reg && (cur_data != g_color_reg);
    assign g_ready  = !(g_valid_reg && g_slot_reg && q_full);
    assign in_ready = !clearing_reg && g_ready;

    assign push           = g_valid_reg && g_slot_reg && !q_full;
    assign push_data.word = cur_data;
    assign push_data.idle = !g_hit_reg;

    always_comb
    begin
        // A write leaving the second stage this cycle precedes the slot here
        restart   = (pending_reg || g_set) && (remain_reg == '0);
        slot_pos  = restart ? '0 : pos_reg;
        slot_hit  = slot_pos < count_eff;
        write_hit = {1'b0, f_index_reg} < count_eff;
        slot_fire = f_valid_reg && f_slot_reg && g_ready;

        rd_addr_w = f_slot_reg ? {5'd0, slot_pos} : {6'd0, f_index_reg};
        rd_addr   = rd_addr_w[AW-1:0];

        remain_base = restart ? cfg.reset_slots : remain_reg;
        pos_next    = pos_reg;
        pending_next = pending_reg || g_set;
        remain_next = remain_reg;
        if (slot_fire)
        begin
            if (restart)
            begin
                pending_next = 1'b0;
            end
            pos_next    = slot_hit ? slot_pos + 1'b1 : slot_pos;
            remain_next = (!slot_hit && remain_base != '0) ? remain_base - 1'b1 : remain_base;
        end

        mem_we  = clearing_reg || g_set;
        wr_addr = clearing_reg ? clr_cnt_reg : g_addr_reg;
        wr_data = clearing_reg ? '0 : g_color_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (g_ready)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
            pos_reg       <= '0;
            pending_reg   <= 1'b1;
            remain_reg    <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            remain_reg  <= remain_next;
            if (g_ready)
            begin
                f_valid_reg   <= in_valid && in_ready;
                g_valid_reg   <= f_valid_reg;
                // The store read misses a write made on the same edge
                byp_valid_reg <= g_set && (g_addr_reg == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_ready)
        begin
            f_slot_reg   <= in_req == slce_pkg::REQ_SLOT;
            f_index_reg  <= in_index;
            f_color_reg  <= in_color;
            g_slot_reg   <= f_slot_reg;
            g_hit_reg    <= f_slot_reg ? slot_hit : write_hit;
            g_addr_reg   <= rd_addr;
            g_color_reg  <= f_color_reg;
            byp_data_reg <= g_color_reg;
        end
    end

endmodule

// ===== hw/rtl/slce_queue.sv =====
module slce_queue #(
    parameter int DEPTH = slce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  slce_pkg::slot_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output slce_pkg::slot_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    slce_pkg::slot_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full      = cnt_reg == FULL_CNT;
    assign pop_valid = cnt_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/slce_back.sv =====
module slce_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  slce_pkg::cfg_t             cfg,
    input  logic                       q_valid,
    input  slce_pkg::slot_t            q_data,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [slce_pkg::CMP_W-1:0] out_value,
    output logic                       out_idle,
    output logic                       out_last
);

    logic                         cur_valid_reg;
    logic [slce_pkg::COLOR_W-1:0] cur_word_reg;
    logic                         cur_idle_reg;
    logic [slce_pkg::BIT_CNT_W-1:0] bit_cnt_reg;

    logic                       m_valid_reg;
    logic [slce_pkg::CMP_W-1:0] m_value_reg;
    logic                       m_idle_reg;
    logic                       m_last_reg;

    logic emit;
    logic last_bit;

    assign emit     = cur_valid_reg && (!m_valid_reg || out_ready);
    assign last_bit = bit_cnt_reg == slce_pkg::LAST_BIT;
    assign pop      = q_valid && (!cur_valid_reg || (emit && last_bit));

    assign out_valid = m_valid_reg;
    assign out_value = m_value_reg;
    assign out_idle  = m_idle_reg;
    assign out_last  = m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                bit_cnt_reg   <= '0;
            end
            else if (emit)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (last_bit)
                begin
                    cur_valid_reg <= 1'b0;
                end
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_word_reg <= q_data.word;
            cur_idle_reg <= q_data.idle;
        end
        else if (emit)
        begin
            cur_word_reg <= {cur_word_reg[slce_pkg::COLOR_W-2:0], 1'b0};
        end
        if (emit)
        begin
            if (cur_idle_reg)
            begin
                m_value_reg <= '0;
            end
            else
            begin
                m_value_reg <= cur_word_reg[slce_pkg::COLOR_W-1] ? cfg.one_count
                                                                 : cfg.zero_count;
            end
            m_idle_reg <= cur_idle_reg;
            m_last_reg <= last_bit;
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;

    import slce_pkg::*;

    // The colour store is as deep as the default build of the block.
    localparam int MAX_LEDS = MAX_LEDS_DEF;
    // Cycles allowed after the last expected compare value has been taken
    // before the block counts as idle. A request passes the front-end stages
    // and a short queue before it reaches the serialiser.
    localparam int SETTLE_CYCLES = 10;
    // A long hold-off on the output, to fill the block and stall its input.
    localparam int HOLD_CYCLES = 400;
    // Cycles without any transaction before the run is abandoned. The
    // store sweep after reset and the long hold-off are the longest quiet
    // stretches of a correct run.
    localparam int STALL_LIMIT = 4000;

    // One expected compare value, as it should appear on the output.
    typedef struct packed {
        logic [CMP_W-1:0] cmp;
        logic             idle;
        logic             last;
    } code_t;

    // The directed part is a table: either a register write or a request.
    typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  data;
        logic                   req;
        logic [INDEX_W-1:0]     idx;
        logic [COLOR_W-1:0]     col;
        bit                     typed;
        logic [CMP_W-1:0]       t_cmp;
        bit                     t_idle;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Our own copy of the block's state and registers.
    cfg_t                  shadow_cfg;
    logic [COLOR_W-1:0]    colour_store [MAX_LEDS];
    logic [COUNT_W-1:0]    frame_pos;
    bit                    refresh_due;
    logic [RSLOT_W-1:0]    gap_slots_left;

    // Compare values still owed by the block, oldest first.
    code_t                 expected_codes [$];

    int                    mismatches;
    int                    quiet_cycles;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    bit                    hold_request;

    smart_led_chain_bit_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // led_index[9:0], color[33:10], zero pad
        .s_tuser   (s_tuser),   // req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // compare_value[7:0]
        .m_tuser   (m_tuser),   // is_reset
        .m_tlast   (m_tlast)    // last_of_slot
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The number of LEDs actually in use: the register clamped to the store.
    function automatic logic [COUNT_W-1:0] live_count();
        if (shadow_cfg.led_count > COUNT_W'(MAX_LEDS))
            return COUNT_W'(MAX_LEDS);
        return shadow_cfg.led_count;
    endfunction

    // Works out what one accepted request transaction does. A colour write
    // only updates the store; a slot request yields 24 compare values. Where
    // the table gives the result outright, that value replaces the computed
    // one, while the state still moves on as computed.
    task automatic encode_request(input logic req, input logic [INDEX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] col, input bit use_typed,
                                  input logic [CMP_W-1:0] t_cmp, input bit t_idle);
        logic [COUNT_W-1:0] count;
        logic [COLOR_W-1:0] word;
        bit                 sending_led;
        code_t              c;
        int                 k;
        count = live_count();
        if (req == REQ_WRITE)
        begin
            // Writes beyond the chain are dropped; an unchanged colour
            // does not ask for a new frame.
            if ({1'b0, idx} < count && colour_store[idx] != col)
            begin
                colour_store[idx] = col;
                refresh_due = 1'b1;
            end
        end
        else
        begin
            // A new frame starts only once the gap between frames is over.
            if (refresh_due && gap_slots_left == '0)
            begin
                frame_pos      = '0;
                refresh_due    = 1'b0;
                gap_slots_left = shadow_cfg.reset_slots;
            end
            sending_led = (frame_pos < count);
            word = sending_led ? colour_store[frame_pos[INDEX_W-1:0]] : '0;
            for (k = 0; k < SLOT_BITS; k++)
            begin
                if (!sending_led)
                    c.cmp = '0;
                else if (word[SLOT_BITS-1-k])
                    c.cmp = shadow_cfg.one_count;
                else
                    c.cmp = shadow_cfg.zero_count;
                c.idle = !sending_led;
                c.last = (k == SLOT_BITS - 1);
                if (use_typed)
                begin
                    c.cmp  = t_cmp;
                    c.idle = t_idle;
                end
                expected_codes.push_back(c);
            end
            if (sending_led)
                frame_pos = frame_pos + 1'b1;
            else if (gap_slots_left != '0)
                gap_slots_left = gap_slots_left - 1'b1;
        end
    endtask

    // Offers one request transaction and waits until it is taken. After it
    // the sender may idle for a while; otherwise tvalid simply stays high
    // for the next transaction.
    task automatic send_request(input logic req, input logic [INDEX_W-1:0] idx,
                                input logic [COLOR_W-1:0] col, input bit use_typed,
                                input logic [CMP_W-1:0] t_cmp, input bit t_idle);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, col, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_request(req, idx, col, use_typed, t_cmp, t_idle);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    // Writes one register and mirrors it in the shadow copy.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            REG_LED_COUNT:   shadow_cfg.led_count   = data[COUNT_W-1:0];
            REG_RESET_SLOTS: shadow_cfg.reset_slots = data[RSLOT_W-1:0];
            REG_ZERO_COUNT:  shadow_cfg.zero_count  = data[CMP_W-1:0];
            REG_ONE_COUNT:   shadow_cfg.one_count   = data[CMP_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering and waits until the block has handed over everything
    // owed, then a little longer, so that a trailing colour write has also
    // been absorbed before the registers are touched.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A fresh register setting: mostly short chains and short gaps between
    // frames, so that frames restart often, and now and then the extremes.
    task automatic pick_settings();
        int                 pick;
        logic [COUNT_W-1:0] leds;
        pick = $urandom_range(9);
        if (pick < 7)
            leds = COUNT_W'($urandom_range(1, 6));
        else if (pick == 7)
            leds = '0;
        else if (pick == 8)
            leds = COUNT_W'(MAX_LEDS);
        else
            leds = '1;
        write_register(REG_LED_COUNT, CFG_DATA_W'(leds));
        write_register(REG_RESET_SLOTS, CFG_DATA_W'($urandom_range(0, 3)));
        write_register(REG_ZERO_COUNT, CFG_DATA_W'($urandom_range(0, 255)));
        write_register(REG_ONE_COUNT, CFG_DATA_W'($urandom_range(0, 255)));
    endtask

    // Random traffic: slot requests and colour writes inside the chain, with
    // some writes of an unchanged colour, and a share of writes anywhere in
    // the index range. Writes that land beyond the chain are not counted.
    task automatic run_random_requests(input int n);
        int                 taken;
        int                 pick;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] idx;
        logic [COLOR_W-1:0] col;
        taken = 0;
        while (taken < n)
        begin
            pick  = $urandom_range(99);
            count = live_count();
            if (pick < 45)
            begin
                send_request(REQ_SLOT, INDEX_W'($urandom()), COLOR_W'($urandom()),
                             1'b0, '0, 1'b0);
                taken++;
            end
            else if (pick < 85 && count != '0)
            begin
                idx = INDEX_W'($urandom_range(int'(count) - 1));
                if ($urandom_range(4) == 0)
                    col = colour_store[idx];
                else
                    col = COLOR_W'($urandom());
                send_request(REQ_WRITE, idx, col, 1'b0, '0, 1'b0);
                taken++;
            end
            else
            begin
                idx = INDEX_W'($urandom_range(MAX_LEDS - 1));
                col = COLOR_W'($urandom());
                send_request(REQ_WRITE, idx, col, 1'b0, '0, 1'b0);
                if ({1'b0, idx} < count)
                    taken++;
            end
        end
    endtask

    function automatic plan_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.data  = data;
        return r;
    endfunction

    function automatic plan_row_t req_row(input logic req, input logic [INDEX_W-1:0] idx,
                                          input logic [COLOR_W-1:0] col);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_REQ;
        r.req  = req;
        r.idx  = idx;
        r.col  = col;
        return r;
    endfunction

    // A slot request whose 24 values are all the same and known beforehand.
    function automatic plan_row_t slot_row(input logic [CMP_W-1:0] cmp, input bit idle);
        plan_row_t r;
        r        = req_row(REQ_SLOT, '0, '0);
        r.typed  = 1'b1;
        r.t_cmp  = cmp;
        r.t_idle = idle;
        return r;
    endfunction

    // The receiver accepts at random. When asked, it holds off for a long
    // stretch, counted here, so that the block backs up into its input.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every output transaction is checked against the oldest expectation.
    // The same process keeps the watchdog: a run in which no transaction
    // happens on either side for too long is a failure.
    always @(posedge clk)
    begin : check_output
        code_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_codes.size() == 0)
            begin
                if (mismatches < 20)
                    $display("%0t: unexpected output cmp %0d idle %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_codes.pop_front();
                if (m_tdata !== want.cmp || m_tuser !== want.idle || m_tlast !== want.last)
                begin
                    if (mismatches < 20)
                        $display("%0t: expected cmp %0d idle %0b last %0b, got cmp %0d idle %0b last %0b",
                                 $time, want.cmp, want.idle, want.last,
                                 m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("smart_led_chain_bit_encoder: mismatch");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t plan [$];
        plan_row_t row;
        int        mode;
        int        setting;
        int        i;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        tx_idle_pct  = 28;
        rx_idle_pct  = 53;
        hold_request = 1'b0;

        // State of the block straight after reset.
        shadow_cfg.led_count   = LED_COUNT_RST;
        shadow_cfg.reset_slots = RESET_SLOTS_RST;
        shadow_cfg.zero_count  = ZERO_COUNT_RST;
        shadow_cfg.one_count   = ONE_COUNT_RST;
        for (i = 0; i < MAX_LEDS; i++)
            colour_store[i] = '0;
        frame_pos      = '0;
        refresh_due    = 1'b1;
        gap_slots_left = '0;

        // Directed table. The gap between frames is shortened first, or the
        // first frame would leave 240 idle slots to wait out.
        plan.push_back(cfg_row(REG_RESET_SLOTS, 11'd0));
        plan.push_back(cfg_row(REG_LED_COUNT, 11'd2));
        plan.push_back(cfg_row(REG_ZERO_COUNT, 11'd0));
        plan.push_back(cfg_row(REG_ONE_COUNT, 11'd255));
        plan.push_back(req_row(REQ_WRITE, 10'd0, 24'hFFFFFF));
        // The same colour as already stored: no change.
        plan.push_back(req_row(REQ_WRITE, 10'd1, 24'h000000));
        // Index beyond the chain: ignored.
        plan.push_back(req_row(REQ_WRITE, 10'd2, 24'h123456));
        // Frame starts; first LED is all ones.
        plan.push_back(slot_row(8'd255, 1'b0));
        // Second LED is all zeros, and the zero count itself is zero: the
        // value is zero yet the slot still carries LED data.
        plan.push_back(slot_row(8'd0, 1'b0));
        // Past the last LED, and then again with no refresh pending, with
        // the countdown held at zero rather than wrapping.
        plan.push_back(slot_row(8'd0, 1'b1));
        plan.push_back(slot_row(8'd0, 1'b1));
        plan.push_back(req_row(REQ_WRITE, 10'd1, 24'hA5A5A5));
        plan.push_back(slot_row(8'd255, 1'b0));
        plan.push_back(req_row(REQ_SLOT, 10'd0, 24'd0));
        // A count above the store size is clamped to the store.
        plan.push_back(cfg_row(REG_LED_COUNT, 11'h7FF));
        plan.push_back(cfg_row(REG_ZERO_COUNT, 11'd255));
        plan.push_back(cfg_row(REG_ONE_COUNT, 11'd0));
        plan.push_back(req_row(REQ_WRITE, 10'd1023, 24'h5A5A5A));
        // A new frame; the first LED is all ones and the one count is zero.
        plan.push_back(slot_row(8'd0, 1'b0));
        // Count lowered mid-frame below the position reached: idle slots.
        plan.push_back(cfg_row(REG_LED_COUNT, 11'd1));
        plan.push_back(slot_row(8'd0, 1'b1));
        // The longest gap is written but replaced before it is ever loaded.
        plan.push_back(cfg_row(REG_RESET_SLOTS, 11'd1023));
        plan.push_back(cfg_row(REG_RESET_SLOTS, 11'd2));
        plan.push_back(req_row(REQ_WRITE, 10'd0, 24'h000001));
        plan.push_back(req_row(REQ_SLOT, 10'd0, 24'd0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_register(row.addr, row.data);
            end
            else
                send_request(row.req, row.idx, row.col, row.typed, row.t_cmp, row.t_idle);
        end

        // Random part: the receiver idles more than the sender, then the
        // other way round, then neither idles at all.
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       begin tx_idle_pct = 28; rx_idle_pct = 53; end
                1:       begin tx_idle_pct = 53; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (setting = 0; setting < 3; setting++)
            begin
                settle();
                pick_settings();
                run_random_requests(16);
            end
        end

        // Back pressure: the receiver stops for a long stretch while slot
        // requests keep coming, so the queue fills and the input stalls.
        settle();
        write_register(REG_LED_COUNT, 11'd4);
        write_register(REG_RESET_SLOTS, 11'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (i = 0; i < 4; i++)
            send_request(REQ_WRITE, INDEX_W'(i), COLOR_W'($urandom()), 1'b0, '0, 1'b0);
        hold_request = 1'b1;
        for (i = 0; i < 12; i++)
            send_request(REQ_SLOT, INDEX_W'($urandom()), COLOR_W'($urandom()),
                         1'b0, '0, 1'b0);

        settle();
        if (mismatches == 0)
            $display("smart_led_chain_bit_encoder: match");
        else
            $display("smart_led_chain_bit_encoder: mismatch");
        $finish;
    end

endmodule
